### rtl/jttq_pkg.sv
// ============================================================================
// jttq_pkg
// Shared types and constants for the Jacobian-transpose joint torque block.
// ============================================================================
package jttq_pkg;

    localparam int FIELD_W   = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ERR_W     = 25;
    localparam int SUMSQ_W   = 50;
    localparam int LIM2_W    = 32;
    localparam int NUM_W     = 41;
    localparam int DOT_W     = 50;
    localparam int DIFF_W    = 43;
    localparam int TQ_W      = 32;

    // Serial multiplier: signed A by signed B, one bit of B per cycle.
    localparam int MUL_A_W   = 50;
    localparam int MUL_B_W   = 25;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 5;

    // Square root: two radicand bits per cycle.
    localparam int SQRT_IN_W  = 50;
    localparam int SQRT_OUT_W = 25;
    localparam int SQRT_CNT_W = 5;

    // Divider: one quotient bit per cycle.
    localparam int DIV_N_W   = 41;
    localparam int DIV_D_W   = 25;
    localparam int DIV_CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 2'd2;

    localparam logic [CFG_W-1:0] POSITION_GAIN_RST = 16'd6400;
    localparam logic [CFG_W-1:0] VELOCITY_GAIN_RST = 16'd3840;
    localparam logic [CFG_W-1:0] ERROR_LIMIT_RST   = 16'd6554;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_JOINT = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [FIELD_W-1:0]  target_x;
        logic signed [FIELD_W-1:0]  target_y;
        logic signed [FIELD_W-1:0]  target_z;
        logic signed [FIELD_W-1:0]  pos_x;
        logic signed [FIELD_W-1:0]  pos_y;
        logic signed [FIELD_W-1:0]  pos_z;
        logic signed [FIELD_W-1:0]  jac_x;
        logic signed [FIELD_W-1:0]  jac_y;
        logic signed [FIELD_W-1:0]  jac_z;
        logic signed [FIELD_W-1:0]  joint_vel;
        logic                       last_joint;
    } t_in_item;

    typedef struct packed {
        logic signed [TQ_W-1:0] torque;
        logic                   saturated;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_CMP,
        S_SQRT,
        S_SMUL,
        S_SDIV,
        S_DOT,
        S_PG,
        S_VG,
        S_OUT
    } t_state;

endpackage

### rtl/jttq_mul.sv
// ============================================================================
// jttq_mul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ============================================================================
module jttq_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [jttq_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [jttq_pkg::MUL_B_W-1:0]    i_b,
    output logic                                   o_done,
    output logic signed [jttq_pkg::MUL_P_W-1:0]    o_p
);
    import jttq_pkg::*;

    logic signed [MUL_A_W-1:0]   r_a;
    logic signed [MUL_A_W:0]     r_hi;
    logic [MUL_B_W-1:0]          r_lo;
    logic [MUL_CNT_W-1:0]        r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic                        last;
    logic signed [MUL_A_W:0]     a_ext;
    logic signed [MUL_A_W:0]     addend;
    logic signed [MUL_A_W:0]     sum;
    logic signed [MUL_A_W:0]     n_hi;
    logic [MUL_B_W-1:0]          n_lo;

    // The top bit of B carries negative weight, so the last step subtracts.
    always_comb begin
        last   = (r_cnt == MUL_CNT_W'(MUL_B_W - 1));
        a_ext  = {r_a[MUL_A_W-1], r_a};
        addend = last ? -a_ext : a_ext;
        sum    = r_lo[0] ? (r_hi + addend) : r_hi;
        n_hi   = {sum[MUL_A_W], sum[MUL_A_W:1]};
        n_lo   = {sum[0], r_lo[MUL_B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= n_hi;
                r_lo  <= n_lo;
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = {r_hi[MUL_A_W-1:0], r_lo};

endmodule

### rtl/jttq_sqrt.sv
// ============================================================================
// jttq_sqrt
// Restoring integer square root, one root bit per cycle.
// ============================================================================
module jttq_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [jttq_pkg::SQRT_IN_W-1:0]  i_rad,
    output logic                            o_done,
    output logic [jttq_pkg::SQRT_OUT_W-1:0] o_root
);
    import jttq_pkg::*;

    logic [SQRT_IN_W-1:0]    r_rad;
    logic [SQRT_OUT_W+1:0]   r_rem;
    logic [SQRT_OUT_W-1:0]   r_root;
    logic [SQRT_CNT_W-1:0]   r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic [SQRT_OUT_W+3:0]   rem_t;
    logic [SQRT_OUT_W+3:0]   trial;
    logic                    take;
    logic                    last;

    always_comb begin
        rem_t = {r_rem, r_rad[SQRT_IN_W-1 -: 2]};
        trial = {2'b00, r_root, 2'b01};
        take  = (rem_t >= trial);
        last  = (r_cnt == SQRT_CNT_W'(SQRT_OUT_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad <= {r_rad[SQRT_IN_W-3:0], 2'b00};
                if (take) begin
                    r_rem  <= (SQRT_OUT_W+2)'(rem_t - trial);
                    r_root <= {r_root[SQRT_OUT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_t[SQRT_OUT_W+1:0];
                    r_root <= {r_root[SQRT_OUT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/jttq_div.sv
// ============================================================================
// jttq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module jttq_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [jttq_pkg::DIV_N_W-1:0] i_num,
    input  logic [jttq_pkg::DIV_D_W-1:0] i_den,
    output logic                         o_done,
    output logic [jttq_pkg::DIV_N_W-1:0] o_quo
);
    import jttq_pkg::*;

    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_D_W:0]     rem_t;
    logic                 take;
    logic                 last;

    always_comb begin
        rem_t = {r_rem, r_quo[DIV_N_W-1]};
        take  = (rem_t >= {1'b0, r_den});
        last  = (r_cnt == DIV_CNT_W'(DIV_N_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= take ? DIV_D_W'(rem_t - {1'b0, r_den}) : rem_t[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], take};
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/jacobian_transpose_joint_torque.sv
// A joint transaction is worked through the serial multiplier and its result is offered;
// a load transaction gives no result and the block is idle again once the error limit is
// checked, or once the error has been scaled by the square root and divider.
// One transaction is taken at a time; the serial multiplier, square root and divider
// set the pace, and a new transaction is not taken until the block is idle again.
// Reset (synchronous, active low) restores the gains and error limit to their
// defaults, clears the stored error to zero and empties the result register.
// ============================================================================
// jacobian_transpose_joint_torque
// Jacobian-transpose controller: clamps the Cartesian error on a load
// transaction and turns each joint transaction into a saturated torque.
// ============================================================================
module jacobian_transpose_joint_torque (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [jttq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jttq_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  jttq_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output jttq_pkg::t_out_item                 o_out_item
);
    import jttq_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] r_pgain;
    logic [CFG_W-1:0] r_vgain;
    logic [CFG_W-1:0] r_elim;

    // Control.
    t_state r_state;
    t_state n_state;
    logic [1:0] r_idx;
    logic       r_launched;

    // Working values.
    logic signed [ERR_W-1:0]   r_e [3];
    logic signed [FIELD_W-1:0] r_jac [3];
    logic signed [FIELD_W-1:0] r_vel;
    logic signed [FIELD_W-1:0] r_ce [3];
    logic [SUMSQ_W-1:0]        r_sumsq;
    logic [LIM2_W-1:0]         r_lim2;
    logic [SQRT_OUT_W-1:0]     r_norm;
    logic [NUM_W-1:0]          r_num;
    logic signed [DOT_W-1:0]   r_dot;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [TQ_W-1:0]    r_tq;
    logic                      r_sat;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    // Unit interfaces.
    logic                       mul_start;
    logic                       mul_done;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic                       sqrt_start;
    logic                       sqrt_done;
    logic [SQRT_OUT_W-1:0]      sqrt_root;
    logic                       div_start;
    logic                       div_done;
    logic [DIV_N_W-1:0]         div_quo;

    // Selected component and helpers.
    logic signed [ERR_W-1:0]   cur_e;
    logic signed [ERR_W-1:0]   cur_abs;
    logic signed [FIELD_W-1:0] cur_jac;
    logic signed [FIELD_W-1:0] cur_ce;
    logic                      accept;
    logic                      out_free;
    logic                      over;
    logic signed [DIFF_W-1:0]  qdot;
    logic signed [50:0]        tq_wide;
    logic [FIELD_W-1:0]        q_low;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // Component chosen by the pass index; index three is used only for the
    // square of the error limit, where the component is not read.
    always_comb begin
        case (r_idx)
            2'd0:    begin cur_e = r_e[0]; cur_jac = r_jac[0]; cur_ce = r_ce[0]; end
            2'd1:    begin cur_e = r_e[1]; cur_jac = r_jac[1]; cur_ce = r_ce[1]; end
            default: begin cur_e = r_e[2]; cur_jac = r_jac[2]; cur_ce = r_ce[2]; end
        endcase
        cur_abs = cur_e[ERR_W-1] ? -cur_e : cur_e;
    end

    // Operand selection for the shared multiplier. The operands are taken
    // only in the cycle in which a product is started.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                if (r_idx == 2'd3) begin
                    mul_a = MUL_A_W'({1'b0, r_elim});
                    mul_b = MUL_B_W'({1'b0, r_elim});
                end else begin
                    mul_a = MUL_A_W'(cur_abs);
                    mul_b = cur_abs;
                end
            end
            S_SMUL: begin
                mul_a = MUL_A_W'(cur_abs);
                mul_b = MUL_B_W'({1'b0, r_elim});
            end
            S_DOT: begin
                mul_a = MUL_A_W'(cur_jac);
                mul_b = MUL_B_W'(cur_ce);
            end
            S_PG: begin
                mul_a = r_dot;
                mul_b = MUL_B_W'({1'b0, r_pgain});
            end
            S_VG: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = MUL_B_W'({1'b0, r_vgain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Start pulses: a working state launches its unit on entry and again after each done that leaves it in place.
    always_comb begin
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_SQ, S_SMUL, S_DOT, S_PG, S_VG: mul_start = !r_launched;
            S_SQRT:                          sqrt_start = !r_launched;
            S_SDIV:                          div_start  = !r_launched;
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_item.action == ACTION_LOAD) ? S_SQ : S_DOT;
                end
            end
            S_SQ:   if (mul_done && r_idx == 2'd3) n_state = S_CMP;
            S_CMP:  n_state = over ? S_SQRT : S_IDLE;
            S_SQRT: if (sqrt_done) n_state = S_SMUL;
            S_SMUL: if (mul_done) n_state = S_SDIV;
            S_SDIV: if (div_done) n_state = (r_idx == 2'd2) ? S_IDLE : S_SMUL;
            S_DOT:  if (mul_done && r_idx == 2'd2) n_state = S_PG;
            S_PG:   if (mul_done) n_state = S_VG;
            S_VG:   if (mul_done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Norm test and the fixed-point tail of the joint path. Shifting right
    // arithmetically rounds toward minus infinity, as required.
    always_comb begin
        over    = (r_sumsq > SUMSQ_W'(r_lim2));
        qdot    = DIFF_W'($signed(mul_p[65:24]));
        tq_wide = mul_p[58:8];
        q_low   = div_quo[FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_launched  <= 1'b0;
            r_pgain     <= POSITION_GAIN_RST;
            r_vgain     <= VELOCITY_GAIN_RST;
            r_elim      <= ERROR_LIMIT_RST;
            r_ce[0]     <= '0;
            r_ce[1]     <= '0;
            r_ce[2]     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_POSITION_GAIN: r_pgain <= i_cfg_data;
                    REG_VELOCITY_GAIN: r_vgain <= i_cfg_data;
                    REG_ERROR_LIMIT:   r_elim  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (mul_start || sqrt_start || div_start) begin
                r_launched <= 1'b1;
            end else if (mul_done || sqrt_done || div_done) begin
                r_launched <= 1'b0;
            end

            // The result register is loaded as the previous result leaves or
            // when it is empty; otherwise it empties on a taken transaction.
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (accept) begin
                r_idx   <= '0;
                r_sumsq <= '0;
                r_dot   <= '0;
                r_e[0]  <= ERR_W'(i_in_item.target_x) - ERR_W'(i_in_item.pos_x);
                r_e[1]  <= ERR_W'(i_in_item.target_y) - ERR_W'(i_in_item.pos_y);
                r_e[2]  <= ERR_W'(i_in_item.target_z) - ERR_W'(i_in_item.pos_z);
                r_jac[0] <= i_in_item.jac_x;
                r_jac[1] <= i_in_item.jac_y;
                r_jac[2] <= i_in_item.jac_z;
                r_vel    <= i_in_item.joint_vel;
            end

            case (r_state)
                S_SQ: begin
                    if (mul_done) begin
                        if (r_idx == 2'd3) begin
                            r_lim2 <= mul_p[LIM2_W-1:0];
                        end else begin
                            r_sumsq <= r_sumsq + mul_p[SUMSQ_W-1:0];
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_CMP: begin
                    r_idx <= '0;
                    if (!over) begin
                        // Within the limit the error is small enough to
                        // fit the stored width unchanged.
                        r_ce[0] <= r_e[0][FIELD_W-1:0];
                        r_ce[1] <= r_e[1][FIELD_W-1:0];
                        r_ce[2] <= r_e[2][FIELD_W-1:0];
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) r_norm <= sqrt_root;
                end
                S_SMUL: begin
                    if (mul_done) r_num <= mul_p[NUM_W-1:0];
                end
                S_SDIV: begin
                    if (div_done) begin
                        // Magnitudes are divided, so the quotient is
                        // truncated toward zero before the sign returns.
                        case (r_idx)
                            2'd0:    r_ce[0] <= cur_e[ERR_W-1] ? -q_low : q_low;
                            2'd1:    r_ce[1] <= cur_e[ERR_W-1] ? -q_low : q_low;
                            default: r_ce[2] <= cur_e[ERR_W-1] ? -q_low : q_low;
                        endcase
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DOT: begin
                    if (mul_done) begin
                        r_dot <= r_dot + mul_p[DOT_W-1:0];
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_PG: begin
                    if (mul_done) r_diff <= qdot - DIFF_W'(r_vel);
                end
                S_VG: begin
                    if (mul_done) begin
                        // Saturate when the bits above the torque width do
                        // not all repeat its sign.
                        if (tq_wide[50:31] != {20{tq_wide[31]}}) begin
                            r_sat <= 1'b1;
                            r_tq  <= tq_wide[50] ? {1'b1, {(TQ_W-1){1'b0}}}
                                                 : {1'b0, {(TQ_W-1){1'b1}}};
                        end else begin
                            r_sat <= 1'b0;
                            r_tq  <= tq_wide[TQ_W-1:0];
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_item.torque    <= r_tq;
                        r_out_item.saturated <= r_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    jttq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    jttq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sumsq),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    jttq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_norm),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
